// ===== sv/rag_pkg.sv =====
// rag_pkg: shared types and constants for the rational arithmetic block.
// Request and result structs, micro-op command and status groups.
// No dependencies.
package rag_pkg;

    localparam int MW = 64;                       // internal magnitude width

    localparam logic [2:0] ACT_NORM = 3'd0;
    localparam logic [2:0] ACT_ADD  = 3'd1;
    localparam logic [2:0] ACT_SUB  = 3'd2;
    localparam logic [2:0] ACT_MUL  = 3'd3;
    localparam logic [2:0] ACT_DIV  = 3'd4;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_DIVZ = 2'd1,
        ST_OVF  = 2'd2
    } t_status;

    typedef struct packed {
        logic [2:0]         action;
        logic signed [31:0] lhs_num;
        logic signed [31:0] lhs_den;
        logic signed [31:0] rhs_num;
        logic [30:0]        rhs_den;
    } t_in;

    typedef struct packed {
        logic signed [31:0] res_num;
        logic [30:0]        res_den;
        t_status            status;
    } t_out;

    typedef enum logic [2:0] {
        OP_GCD = 3'd0,
        OP_DIV = 3'd1,
        OP_MUL = 3'd2,
        OP_ADD = 3'd3,
        OP_SUB = 3'd4,
        OP_FIN = 3'd5
    } t_op;

    // working registers 0..7 live in the register memory, 8..11 come from the request
    typedef enum logic [3:0] {
        R_AN  = 4'd0,
        R_AD  = 4'd1,
        R_BN  = 4'd2,
        R_BD  = 4'd3,
        R_G1  = 4'd4,
        R_G2  = 4'd5,
        R_X   = 4'd6,
        R_Y   = 4'd7,
        R_IAN = 4'd8,
        R_IAD = 4'd9,
        R_IBN = 4'd10,
        R_IBD = 4'd11
    } t_reg;

    typedef struct packed {
        t_op  op;
        t_reg a;
        t_reg b;
        t_reg dst;
    } t_cmd;

    typedef struct packed {
        logic go;
        logic divz;
        t_cmd cmd;
    } t_ctl;

    typedef struct packed {
        logic       done;
        logic [2:0] action;
        logic       a_den_zero;
        logic       b_den_zero;
        logic       b_num_zero;
    } t_sts;

endpackage

// ===== sv/rag_gcd.sv =====
// rag_gcd: binary (shift and subtract) gcd unit, one step per cycle.
// Depends on rag_pkg.
module rag_gcd (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic [rag_pkg::MW-1:0] i_a,
    input  logic [rag_pkg::MW-1:0] i_b,
    output logic                   o_done,
    output logic [rag_pkg::MW-1:0] o_g
);
    import rag_pkg::*;

    localparam int KW = $clog2(MW) + 1;

    logic          r_busy;
    logic          r_done;
    logic [MW-1:0] r_u;
    logic [MW-1:0] r_v;
    logic [MW-1:0] r_g;
    logic [KW-1:0] r_k;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_u    <= i_a;
                r_v    <= i_b;
                r_k    <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (r_v == '0) begin
                    r_g    <= r_u << r_k;
                    r_done <= 1'b1;
                    r_busy <= 1'b0;
                end else if (r_u == '0) begin
                    r_g    <= r_v << r_k;
                    r_done <= 1'b1;
                    r_busy <= 1'b0;
                end else if (!r_u[0] && !r_v[0]) begin
                    r_u <= r_u >> 1;
                    r_v <= r_v >> 1;
                    r_k <= r_k + 1'b1;
                end else if (!r_u[0]) begin
                    r_u <= r_u >> 1;
                end else if (!r_v[0]) begin
                    r_v <= r_v >> 1;
                end else if (r_u >= r_v) begin
                    r_u <= (r_u - r_v) >> 1;
                end else begin
                    r_v <= (r_v - r_u) >> 1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_g    = r_g;

endmodule

// ===== sv/rag_div.sv =====
// rag_div: restoring unsigned divider, one quotient bit per cycle.
// Depends on rag_pkg.
module rag_div (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic [rag_pkg::MW-1:0] i_n,
    input  logic [rag_pkg::MW-1:0] i_d,
    output logic                   o_done,
    output logic [rag_pkg::MW-1:0] o_q
);
    import rag_pkg::*;

    localparam int CW = $clog2(MW) + 1;

    logic          r_busy;
    logic          r_done;
    logic [MW-1:0] r_q;
    logic [MW-1:0] r_r;
    logic [MW-1:0] r_d;
    logic [CW-1:0] r_cnt;
    logic [MW:0]   w_r2;
    logic [MW:0]   w_diff;
    logic          w_ge;

    assign w_r2   = {r_r, r_q[MW-1]};
    assign w_diff = w_r2 - {1'b0, r_d};
    assign w_ge   = w_r2 >= {1'b0, r_d};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_q    <= i_n;
                r_r    <= '0;
                r_d    <= i_d;
                r_cnt  <= CW'(MW);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_q   <= {r_q[MW-2:0], w_ge};
                r_r   <= w_ge ? w_diff[MW-1:0] : w_r2[MW-1:0];
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_q    = r_q;

endmodule

// ===== sv/rag_ctrl.sv =====
// rag_ctrl: sequencer that walks the micro-op program of each request.
// Depends on rag_pkg; drives rag_dp through t_ctl, reads t_sts.
module rag_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_acc,
    output logic          o_ready,
    input  rag_pkg::t_sts i_sts,
    output rag_pkg::t_ctl o_ctl
);
    import rag_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_WAIT
    } t_state;

    t_state     r_state;
    logic       r_go;
    logic       r_divz;
    logic [4:0] r_pc;
    t_cmd       r_cmd;
    logic       w_arith;
    logic       w_err;

    function automatic t_cmd mk(input t_op op, input t_reg a, input t_reg b, input t_reg d);
        t_cmd c;
        c.op  = op;
        c.a   = a;
        c.b   = b;
        c.dst = d;
        return c;
    endfunction

    // program: normalize left; arithmetic actions then normalize right and run their cross-gcd steps
    function automatic t_cmd ucode(input logic [2:0] act, input logic [4:0] pc);
        t_cmd       c;
        logic       arith;
        logic [4:0] k;
        arith = act inside {[ACT_ADD:ACT_DIV]};
        k     = pc - 5'd6;
        c     = mk(OP_FIN, R_AN, R_AD, R_AN);
        if (pc < 5'd3) begin
            case (pc)
                5'd0:    c = mk(OP_GCD, R_IAN, R_IAD, R_G1);
                5'd1:    c = mk(OP_DIV, R_IAN, R_G1, R_AN);
                default: c = mk(OP_DIV, R_IAD, R_G1, R_AD);
            endcase
        end else if (!arith) begin
            c = mk(OP_FIN, R_AN, R_AD, R_AN);
        end else if (pc < 5'd6) begin
            case (pc)
                5'd3:    c = mk(OP_GCD, R_IBN, R_IBD, R_G1);
                5'd4:    c = mk(OP_DIV, R_IBN, R_G1, R_BN);
                default: c = mk(OP_DIV, R_IBD, R_G1, R_BD);
            endcase
        end else if (act == ACT_ADD || act == ACT_SUB) begin
            case (k)
                5'd0:    c = mk(OP_GCD, R_AD, R_BD, R_G1);
                5'd1:    c = mk(OP_DIV, R_BD, R_G1, R_X);
                5'd2:    c = mk(OP_DIV, R_AD, R_G1, R_Y);
                5'd3:    c = mk(OP_MUL, R_AN, R_X, R_X);
                5'd4:    c = mk(OP_MUL, R_Y, R_BN, R_BN);
                5'd5:    c = mk((act == ACT_ADD) ? OP_ADD : OP_SUB, R_X, R_BN, R_X);
                5'd6:    c = mk(OP_GCD, R_X, R_G1, R_G2);
                5'd7:    c = mk(OP_DIV, R_X, R_G2, R_X);
                5'd8:    c = mk(OP_DIV, R_BD, R_G2, R_BD);
                5'd9:    c = mk(OP_MUL, R_Y, R_BD, R_BD);
                default: c = mk(OP_FIN, R_X, R_BD, R_X);
            endcase
        end else if (act == ACT_MUL) begin
            case (k)
                5'd0:    c = mk(OP_GCD, R_AN, R_BD, R_G1);
                5'd1:    c = mk(OP_GCD, R_AD, R_BN, R_G2);
                5'd2:    c = mk(OP_DIV, R_AN, R_G1, R_AN);
                5'd3:    c = mk(OP_DIV, R_BN, R_G2, R_BN);
                5'd4:    c = mk(OP_DIV, R_AD, R_G2, R_AD);
                5'd5:    c = mk(OP_DIV, R_BD, R_G1, R_BD);
                5'd6:    c = mk(OP_MUL, R_AN, R_BN, R_X);
                5'd7:    c = mk(OP_MUL, R_AD, R_BD, R_Y);
                default: c = mk(OP_FIN, R_X, R_Y, R_X);
            endcase
        end else begin
            case (k)
                5'd0:    c = mk(OP_GCD, R_AN, R_BN, R_G1);
                5'd1:    c = mk(OP_GCD, R_AD, R_BD, R_G2);
                5'd2:    c = mk(OP_DIV, R_AN, R_G1, R_AN);
                5'd3:    c = mk(OP_DIV, R_BD, R_G2, R_BD);
                5'd4:    c = mk(OP_DIV, R_AD, R_G2, R_AD);
                5'd5:    c = mk(OP_DIV, R_BN, R_G1, R_BN);
                5'd6:    c = mk(OP_MUL, R_AN, R_BD, R_X);
                5'd7:    c = mk(OP_MUL, R_AD, R_BN, R_Y);
                default: c = mk(OP_FIN, R_X, R_Y, R_X);   // sign fixed at finish
            endcase
        end
        return c;
    endfunction

    assign w_arith = i_sts.action inside {[ACT_ADD:ACT_DIV]};
    assign w_err   = i_sts.a_den_zero ||
                     (w_arith && (i_sts.b_den_zero ||
                                  (i_sts.action == ACT_DIV && i_sts.b_num_zero)));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_go    <= 1'b0;
            r_divz  <= 1'b0;
            r_pc    <= '0;
        end else begin
            r_go <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_in_acc) begin
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    r_divz  <= w_err;
                    r_pc    <= '0;
                    r_cmd   <= w_err ? mk(OP_FIN, R_AN, R_AD, R_AN)
                                     : ucode(i_sts.action, 5'd0);
                    r_go    <= 1'b1;
                    r_state <= S_WAIT;
                end
                S_WAIT: begin
                    if (i_sts.done) begin
                        if (r_cmd.op == OP_FIN) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_pc  <= r_pc + 5'd1;
                            r_cmd <= ucode(i_sts.action, r_pc + 5'd1);
                            r_go  <= 1'b1;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_ready    = (r_state == S_IDLE);
    assign o_ctl.go   = r_go;
    assign o_ctl.divz = r_divz;
    assign o_ctl.cmd  = r_cmd;

endmodule

// ===== sv/rag_dp.sv =====
// rag_dp: datapath with request register, 8-entry working register memory,
// gcd and divider units, multiplier, adder and the result register. Depends on rag_pkg.
module rag_dp #(
    parameter int WIDTH = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_acc,
    input  rag_pkg::t_in  i_in,
    input  rag_pkg::t_ctl i_ctl,
    output rag_pkg::t_sts o_sts,
    output logic          o_valid,
    input  logic          i_ready,
    output rag_pkg::t_out o_out
);
    import rag_pkg::*;

    localparam logic [MW-1:0] LIM = MW'(1) << (WIDTH - 1);

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_FETCH,
        PH_BUSY
    } t_ph;

    t_in           r_in;
    t_cmd          r_cmd;
    t_ph           r_ph;
    logic          r_done;
    logic          r_out_valid;
    t_out          r_out;
    logic [MW:0]   mem [8];
    logic [MW:0]   r_rda;
    logic [MW:0]   r_rdb;

    logic [MW:0]   w_ian, w_iad, w_ibn, w_ibd;
    logic [MW:0]   w_opa, w_opb;
    logic [MW-1:0] w_prod;
    logic [MW+1:0] w_sa, w_sb, w_sum, w_smag;
    logic          w_start_gcd, w_start_div;
    logic          w_gcd_done, w_div_done, w_unit_done;
    logic [MW-1:0] w_gcd_g, w_div_q;
    logic          w_wr;
    logic [MW:0]   w_wdata;
    logic          w_fin_wr;
    logic          w_fs;
    logic          w_ovf;
    t_out          w_fout;
    logic [31:0]   w_lnm, w_ldm, w_rnm;

    // sign and magnitude of request operands (left sign folded into numerator)
    assign w_lnm = r_in.lhs_num[31] ? 32'(-r_in.lhs_num) : r_in.lhs_num;
    assign w_ldm = r_in.lhs_den[31] ? 32'(-r_in.lhs_den) : r_in.lhs_den;
    assign w_rnm = r_in.rhs_num[31] ? 32'(-r_in.rhs_num) : r_in.rhs_num;
    assign w_ian = {r_in.lhs_num[31] ^ r_in.lhs_den[31], 32'b0, w_lnm};
    assign w_iad = {1'b0, 32'b0, w_ldm};
    assign w_ibn = {r_in.rhs_num[31], 32'b0, w_rnm};
    assign w_ibd = {1'b0, 33'b0, r_in.rhs_den};

    always_comb begin
        case (r_cmd.a)
            R_IAN:   w_opa = w_ian;
            R_IAD:   w_opa = w_iad;
            R_IBN:   w_opa = w_ibn;
            R_IBD:   w_opa = w_ibd;
            default: w_opa = r_rda;
        endcase
        case (r_cmd.b)
            R_IAN:   w_opb = w_ian;
            R_IAD:   w_opb = w_iad;
            R_IBN:   w_opb = w_ibn;
            R_IBD:   w_opb = w_ibd;
            default: w_opb = r_rdb;
        endcase
    end

    // operands of a product are reduced values, at most 2^31
    assign w_prod = w_opa[31:0] * w_opb[31:0];
    assign w_sa   = w_opa[MW] ? ('0 - {2'b0, w_opa[MW-1:0]}) : {2'b0, w_opa[MW-1:0]};
    assign w_sb   = w_opb[MW] ? ('0 - {2'b0, w_opb[MW-1:0]}) : {2'b0, w_opb[MW-1:0]};
    assign w_sum  = (r_cmd.op == OP_ADD) ? (w_sa + w_sb) : (w_sa - w_sb);
    assign w_smag = w_sum[MW+1] ? ('0 - w_sum) : w_sum;

    assign w_start_gcd = (r_ph == PH_FETCH) && (r_cmd.op == OP_GCD);
    assign w_start_div = (r_ph == PH_FETCH) && (r_cmd.op == OP_DIV);

    rag_gcd u_gcd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start_gcd),
        .i_a     (w_opa[MW-1:0]),
        .i_b     (w_opb[MW-1:0]),
        .o_done  (w_gcd_done),
        .o_g     (w_gcd_g)
    );

    rag_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start_div),
        .i_n     (w_opa[MW-1:0]),
        .i_d     (w_opb[MW-1:0]),
        .o_done  (w_div_done),
        .o_q     (w_div_q)
    );

    assign w_unit_done = (r_cmd.op == OP_GCD) ? w_gcd_done : w_div_done;

    always_comb begin
        w_wr    = 1'b0;
        w_wdata = '0;
        if (r_ph == PH_FETCH) begin
            case (r_cmd.op)
                OP_MUL: begin
                    w_wr    = 1'b1;
                    w_wdata = {w_opa[MW] ^ w_opb[MW], w_prod};
                end
                OP_ADD, OP_SUB: begin
                    w_wr    = 1'b1;
                    w_wdata = {w_sum[MW+1], w_smag[MW-1:0]};
                end
                default: begin
                    w_wr = 1'b0;
                end
            endcase
        end else if (r_ph == PH_BUSY && w_unit_done) begin
            w_wr    = 1'b1;
            w_wdata = (r_cmd.op == OP_GCD) ? {1'b0, w_gcd_g} : {w_opa[MW], w_div_q};
        end
    end

    // finish: numerator sign carries the denominator sign too
    assign w_fs  = w_opa[MW] ^ w_opb[MW];
    assign w_ovf = (w_opb[MW-1:0] > LIM - 1'b1) ||
                   (!w_fs && w_opa[MW-1:0] > LIM - 1'b1) ||
                   (w_fs && w_opa[MW-1:0] > LIM);

    always_comb begin
        w_fout = '0;
        if (i_ctl.divz) begin
            w_fout.status = ST_DIVZ;
        end else if (w_ovf) begin
            w_fout.status = ST_OVF;
        end else begin
            w_fout.status  = ST_OK;
            w_fout.res_num = w_fs ? 32'(-w_opa[31:0]) : w_opa[31:0];
            w_fout.res_den = w_opb[30:0];
        end
    end

    assign w_fin_wr = (r_ph == PH_FETCH) && (r_cmd.op == OP_FIN) &&
                      (!r_out_valid || i_ready);

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            mem[r_cmd.dst[2:0]] <= w_wdata;
        end
        if (i_ctl.go) begin
            r_rda <= mem[i_ctl.cmd.a[2:0]];
            r_rdb <= mem[i_ctl.cmd.b[2:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph        <= PH_IDLE;
            r_done      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_in_acc) begin
                r_in <= i_in;
            end
            if (i_ctl.go) begin
                r_cmd <= i_ctl.cmd;
            end
            r_done <= w_wr || w_fin_wr;
            if (w_fin_wr) begin
                r_out_valid <= 1'b1;
                r_out       <= w_fout;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_ph)
                PH_IDLE: begin
                    if (i_ctl.go) begin
                        r_ph <= PH_FETCH;
                    end
                end
                PH_FETCH: begin
                    case (r_cmd.op)
                        OP_GCD, OP_DIV: r_ph <= PH_BUSY;
                        OP_FIN:         r_ph <= w_fin_wr ? PH_IDLE : PH_FETCH;
                        default:        r_ph <= PH_IDLE;
                    endcase
                end
                PH_BUSY: begin
                    if (w_unit_done) begin
                        r_ph <= PH_IDLE;
                    end
                end
                default: begin
                    r_ph <= PH_IDLE;
                end
            endcase
        end
    end

    assign o_sts.done       = r_done;
    assign o_sts.action     = r_in.action;
    assign o_sts.a_den_zero = (r_in.lhs_den == '0);
    assign o_sts.b_den_zero = (r_in.rhs_den == '0);
    assign o_sts.b_num_zero = (r_in.rhs_num == '0);
    assign o_valid          = r_out_valid;
    assign o_out            = r_out;

endmodule

// ===== sv/rational_arith_gcd_reduce.sv =====
// rational_arith_gcd_reduce: top level, rational add/sub/mul/div/normalize
// with gcd reduction. Depends on rag_pkg, rag_ctrl, rag_dp (rag_gcd, rag_div).
//
// Usage:
//   Request channel i_valid/o_ready/i_in carries action and two fractions.
//   Result channel o_valid/i_ready/o_out returns one reduced fraction and a
//   status (ok, divide by zero, overflow) per request, in order.
//   One request is worked at a time: o_ready is high only while the sequencer
//   is idle. The result sits in an output register, so the next request is
//   taken while a finished result still waits for i_ready.
// Program:
//   Each request runs a short micro-op program on the datapath: multiply
//   and add micro-ops write back from the fetch phase, a division produces
//   64 quotient bits, and a gcd runs shift/subtract steps until one operand
//   is zero. Normalize has the shortest program, add/subtract the longest.
//   An error found at the start skips to the finish step. o_ready returns
//   once the sequencer sees the finish step complete.
// Reset: synchronous, active low; clears sequencer, unit and output valid
//   state. No clearing pass is needed.
// Stall: a full output register that is not taken holds the finish step;
//   nothing is lost or repeated.
module rational_arith_gcd_reduce #(
    parameter int WIDTH = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  rag_pkg::t_in  i_in,
    output logic          o_valid,
    input  logic          i_ready,
    output rag_pkg::t_out o_out
);
    import rag_pkg::*;

    t_ctl w_ctl;
    t_sts w_sts;
    logic w_in_acc;

    assign w_in_acc = i_valid && o_ready;

    // sequencer: steps through the program, one micro-op at a time
    rag_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in_acc (w_in_acc),
        .o_ready  (o_ready),
        .i_sts    (w_sts),
        .o_ctl    (w_ctl)
    );

    // datapath: request register, working registers, arithmetic units, result
    rag_dp #(
        .WIDTH (WIDTH)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in_acc (w_in_acc),
        .i_in     (i_in),
        .i_ctl    (w_ctl),
        .o_sts    (w_sts),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_out    (o_out)
    );

    // micro-ops are only issued while a request is in flight
    a_go_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.go |-> !o_ready)
        else $error("micro-op issued while idle");

    // a completion only arrives while the sequencer waits for it
    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_sts.done |-> !o_ready)
        else $error("completion seen while idle");

    // a new result appears only together with a finished micro-op
    a_out_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> w_sts.done)
        else $error("result without finish step");

endmodule

// ===== tb/sv/rational_arith_gcd_reduce_test.sv =====
// rational_arith_gcd_reduce_test: self-checking bench for the rational arithmetic block.
// Drives a stimulus table and random traffic, checks results against typed values or
// an in-bench predictor. Depends on rag_pkg and rational_arith_gcd_reduce.
module rational_arith_gcd_reduce_test;
    timeunit 1ns;
    timeprecision 1ps;
    import rag_pkg::*;

    localparam int WIDTH = 32;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic i_ready = 1'b0;
    logic o_ready, o_valid;
    t_in  i_in = '0;
    t_out o_out;

    always #10 i_clk = ~i_clk;

    rational_arith_gcd_reduce #(.WIDTH(WIDTH)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_in(i_in), .o_valid(o_valid), .i_ready(i_ready), .o_out(o_out)
    );

    t_out pending_q[$];       // expected fractions, oldest first
    int   n_bad = 0;
    int   send_idle_pct = 9;  // percent of cycles the sender holds back
    int   recv_idle_pct = 46; // percent of cycles the receiver holds back
    bit   hold_go = 1'b0;     // starts the long receiver stall
    bit   hold_seen = 1'b0;
    int   hold_left = 0;      // long receiver stall, counted down below

    // ---- predictor -------------------------------------------------------
    function automatic longint unsigned mag(longint x);
        return (x < 0) ? -x : x;
    endfunction

    function automatic longint euclid(longint u, longint v);
        longint unsigned a, b, t;
        a = mag(u);
        b = mag(v);
        while (b != 0) begin
            t = a % b;
            a = b;
            b = t;
        end
        return longint'(a);
    endfunction

    // lowest terms, positive denominator; returns 0 on zero denominator
    function automatic bit reduce_frac(longint n, longint d, output longint on, output longint od);
        longint g;
        on = 0;
        od = 1;
        if (d == 0) return 1'b0;
        if (d < 0) begin
            n = -n;
            d = -d;
        end
        if (n == 0) return 1'b1;
        g = euclid(n, d);
        on = n / g;
        od = d / g;
        return 1'b1;
    endfunction

    function automatic t_out predict_frac(t_in r);
        longint an, ad, bn, bd, rn, rd, g1, g2, p, q, t, lim;
        t_status st;
        t_out o;
        rn = 0;
        rd = 1;
        st = ST_OK;
        lim = longint'(1) <<< (WIDTH - 1);
        if (!reduce_frac(longint'(r.lhs_num), longint'(r.lhs_den), an, ad)) begin
            st = ST_DIVZ;
        end else if (r.action < ACT_ADD || r.action > ACT_DIV) begin
            rn = an;
            rd = ad;
        end else if (!reduce_frac(longint'(r.rhs_num), longint'({1'b0, r.rhs_den}), bn, bd)) begin
            st = ST_DIVZ;
        end else if (r.action == ACT_ADD || r.action == ACT_SUB) begin
            g1 = euclid(ad, bd);
            p = an * (bd / g1);
            q = (ad / g1) * bn;
            t = (r.action == ACT_ADD) ? p + q : p - q;
            g2 = euclid(t, g1);
            rn = t / g2;
            rd = (ad / g1) * (bd / g2);
        end else if (r.action == ACT_MUL) begin
            g1 = euclid(an, bd);
            g2 = euclid(ad, bn);
            rn = (an / g1) * (bn / g2);
            rd = (ad / g2) * (bd / g1);
        end else if (bn == 0) begin
            st = ST_DIVZ;
        end else begin
            g1 = euclid(an, bn);
            g2 = euclid(ad, bd);
            rn = (an / g1) * (bd / g2);
            rd = (ad / g2) * (bn / g1);
            if (rd < 0) begin
                rn = -rn;
                rd = -rd;
            end
        end
        if (st == ST_OK && (rn < -lim || rn > lim - 1 || rd > lim - 1)) st = ST_OVF;
        if (st != ST_OK) begin
            rn = 0;
            rd = 0;
        end
        o.res_num = rn[31:0];
        o.res_den = rd[30:0];
        o.status = st;
        return o;
    endfunction

    // ---- directed table: hand-typed result where obvious, else predictor --
    typedef struct {
        t_in  req;
        bit   typed;
        t_out want;
    } t_row;

    localparam logic signed [31:0] MINI = 32'sh8000_0000;
    localparam logic signed [31:0] MAXI = 32'sh7FFF_FFFF;
    localparam logic [30:0] MAXD = 31'h7FFF_FFFF;

    t_row directed[] = '{
        '{'{ACT_NORM, 32'sd6, -32'sd4, 32'sd0, 31'd1}, 1, '{-32'sd3, 31'd2, ST_OK}},
        '{'{ACT_NORM, 32'sd0, -32'sd7, 32'sd0, 31'd1}, 1, '{32'sd0, 31'd1, ST_OK}},
        '{'{ACT_NORM, 32'sd5, 32'sd0, 32'sd0, 31'd1}, 1, '{32'sd0, 31'd0, ST_DIVZ}},
        '{'{ACT_NORM, MINI, -32'sd1, 32'sd0, 31'd1}, 1, '{32'sd0, 31'd0, ST_OVF}},
        '{'{ACT_NORM, MINI, MINI, 32'sd0, 31'd1}, 1, '{32'sd1, 31'd1, ST_OK}},
        '{'{ACT_NORM, 32'sd3, MINI, 32'sd0, 31'd0}, 1, '{32'sd0, 31'd0, ST_OVF}},
        '{'{ACT_NORM, MAXI, MAXI, -32'sd1, MAXD}, 1, '{32'sd1, 31'd1, ST_OK}},
        '{'{3'd5, 32'sd4, 32'sd8, 32'sd0, 31'd0}, 1, '{32'sd1, 31'd2, ST_OK}},
        '{'{3'd6, -32'sd9, 32'sd3, 32'sd1, 31'd1}, 1, '{-32'sd3, 31'd1, ST_OK}},
        '{'{3'd7, 32'sd1, -32'sd1, 32'sd1, 31'd1}, 1, '{-32'sd1, 31'd1, ST_OK}},
        '{'{ACT_ADD, 32'sd1, 32'sd2, 32'sd1, 31'd3}, 1, '{32'sd5, 31'd6, ST_OK}},
        '{'{ACT_ADD, 32'sd1, 32'sd2, 32'sd1, 31'd0}, 1, '{32'sd0, 31'd0, ST_DIVZ}},
        '{'{ACT_ADD, MAXI, 32'sd1, MAXI, 31'd1}, 1, '{32'sd0, 31'd0, ST_OVF}},
        '{'{ACT_SUB, 32'sd1, 32'sd6, 32'sd1, 31'd3}, 1, '{-32'sd1, 31'd6, ST_OK}},
        '{'{ACT_SUB, MINI, 32'sd1, 32'sd1, 31'd1}, 1, '{32'sd0, 31'd0, ST_OVF}},
        '{'{ACT_SUB, 32'sd2, -32'sd4, -32'sd6, 31'd12}, 0, '0},
        '{'{ACT_MUL, 32'sd2, 32'sd3, 32'sd9, 31'd4}, 1, '{32'sd3, 31'd2, ST_OK}},
        '{'{ACT_MUL, 32'sd1, MAXI, 32'sd1, MAXD}, 1, '{32'sd0, 31'd0, ST_OVF}},
        '{'{ACT_MUL, MINI, 32'sd1, -32'sd1, 31'd1}, 1, '{32'sd0, 31'd0, ST_OVF}},
        '{'{ACT_DIV, 32'sd1, 32'sd2, 32'sd0, 31'd5}, 1, '{32'sd0, 31'd0, ST_DIVZ}},
        '{'{ACT_DIV, 32'sd3, 32'sd4, -32'sd9, 31'd8}, 1, '{-32'sd2, 31'd3, ST_OK}},
        '{'{ACT_DIV, 32'sd0, 32'sd0, 32'sd0, 31'd0}, 1, '{32'sd0, 31'd0, ST_DIVZ}},
        '{'{ACT_DIV, MINI, MAXI, MAXI, MAXD}, 0, '0},
        '{'{ACT_DIV, -32'sd1, 32'sd1, -32'sd1, MAXD}, 1, '{MAXI, 31'd1, ST_OK}}
    };

    // ---- random request shapes -------------------------------------------
    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return $urandom_range(0, 40);
            2: return -$urandom_range(0, 40);
            3: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
            4: return $urandom_range(0, 65535);
            default: return $urandom & ((32'h1 << $urandom_range(1, 31)) - 1);
        endcase
    endfunction

    function automatic t_in make_req();
        t_in r;
        r.action = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7))
                                                : 3'($urandom_range(0, 4));
        r.lhs_num = pick_word();
        r.lhs_den = ($urandom_range(0, 49) == 0) ? 32'sd0 : pick_word();
        r.rhs_num = pick_word();
        r.rhs_den = ($urandom_range(0, 49) == 0) ? 31'd0 : 31'(pick_word());
        // keep most denominators nonzero so results are mostly usable
        if (r.lhs_den == 0 && $urandom_range(0, 1)) r.lhs_den = 32'sd1;
        return r;
    endfunction

    // Offer one request and hold it until taken; random pre-gap per idle rate.
    // Valid stays high after the accept; the caller drops it before a pause.
    task automatic send_req(t_in r, bit typed, t_out want);
        if ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(0, 99) < send_idle_pct) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_in <= r;
        pending_q.push_back(typed ? want : predict_frac(r));
        do @(posedge i_clk); while (!o_ready);
    endtask

    // ---- long receiver stall ---------------------------------------------
    always @(posedge i_clk) begin
        if (hold_go && !hold_seen) begin
            hold_seen <= 1'b1;
            hold_left <= 3000;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // ---- result side -----------------------------------------------------
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_q.size() == 0) begin
                n_bad++;
                if (n_bad <= 10) $display("unexpected result %p", o_out);
            end else begin
                t_out want;
                want = pending_q.pop_front();
                if (o_out !== want) begin
                    n_bad++;
                    if (n_bad <= 10)
                        $display("mismatch: want %0d/%0d st %0d, got %0d/%0d st %0d",
                                 want.res_num, want.res_den, want.status,
                                 o_out.res_num, o_out.res_den, o_out.status);
                end
            end
        end
    end

    task automatic drain();
        while (pending_q.size() != 0) @(posedge i_clk);
    endtask

    // ---- main sequence ---------------------------------------------------
    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[k]) send_req(directed[k].req, directed[k].typed, directed[k].want);

        // long receiver stall while requests keep coming: output fills, input stalls
        hold_go = 1'b1;
        for (int k = 0; k < 6; k++) send_req(make_req(), 0, '0);
        i_valid <= 1'b0;
        drain();   // sender pauses until all results are back

        for (int ph = 0; ph < 3; ph++) begin
            send_idle_pct = (ph == 0) ? 9 : (ph == 1) ? 46 : 0;
            recv_idle_pct = (ph == 0) ? 46 : (ph == 1) ? 9 : 0;
            for (int k = 0; k < 330; k++) send_req(make_req(), 0, '0);
        end

        i_valid <= 1'b0;
        drain();
        repeat (1000) @(posedge i_clk);
        if (n_bad == 0 && pending_q.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // worst case ~1000 requests plus stalls, several times over
    initial begin
        #200ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
